@@ rtl/core/fba_pkg.sv @@
`timescale 1ns / 1ps

package fba_pkg;

	localparam int FUNC_W   = 2;
	localparam int FRAME_W  = 12;
	localparam int FCOUNT_W = 13;
	localparam int STATUS_W = 2;

	localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = 13'd4096;

	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TEST  = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_KEEP    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOFRAME = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [FRAME_W-1:0] current_frame;
		logic [FRAME_W-1:0] frame_number;
		logic               for_kernel;
		logic               writable;
	} fba_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FRAME_W-1:0]  entry_frame;
		logic                entry_present;
		logic                entry_rw;
		logic                entry_user;
		logic                frame_in_use;
	} fba_rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN0,
		ST_SCAN,
		ST_SPLIT,
		ST_SPLIT2,
		ST_READ,
		ST_MODIFY,
		ST_DONE
	} fba_state_t;

endpackage

@@ rtl/core/fba_bitmap_ram.sv @@
`timescale 1ns / 1ps

module fba_bitmap_ram #(
	parameter int DEPTH  = 128,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = 7
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/fba_index_split.sv @@
`timescale 1ns / 1ps

// Split a frame index into bitmap word and bit position: word = idx / WORD_BITS
// by reciprocal multiply (exact for 12-bit indexes), bit = idx - word * WORD_BITS.
module fba_index_split #(
	parameter int WORD_BITS = 32
) (
	input  logic                                clk,
	input  logic [fba_pkg::FRAME_W-1:0]         idx,
	output logic [fba_pkg::FRAME_W-1:0]         word_s2,
	output logic [$clog2(WORD_BITS)-1:0]        bit_s2
);

	localparam int SHIFT   = 24;
	localparam int RECIP_W = SHIFT + 1;
	localparam int PROD_W  = fba_pkg::FRAME_W + RECIP_W;
	localparam int RECIP   = ((2 ** SHIFT) + WORD_BITS - 1) / WORD_BITS;
	localparam int BW      = $clog2(WORD_BITS);

	logic [PROD_W-1:0]           prod;
	logic [fba_pkg::FRAME_W-1:0] q_s1;
	logic [fba_pkg::FRAME_W-1:0] idx_s1;
	logic [fba_pkg::FRAME_W-1:0] qw;
	logic [fba_pkg::FRAME_W-1:0] rem;

	assign prod = PROD_W'(idx) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		q_s1   <= prod[SHIFT +: fba_pkg::FRAME_W];
		idx_s1 <= idx;
	end

	assign qw  = q_s1 * fba_pkg::FRAME_W'(WORD_BITS);
	assign rem = idx_s1 - qw;

	always_ff @(posedge clk) begin
		word_s2 <= q_s1;
		bit_s2  <= rem[BW-1:0];
	end

endmodule

@@ rtl/core/fba_lowest_free.sv @@
`timescale 1ns / 1ps

// Lowest clear bit among the first 'room' bits of a bitmap word.
module fba_lowest_free #(
	parameter int WIDTH = 32,
	parameter int CW    = 13
) (
	input  logic [WIDTH-1:0]         data,
	input  logic [CW-1:0]            room,
	output logic                     found,
	output logic [$clog2(WIDTH)-1:0] bit_idx
);

	localparam int BW = $clog2(WIDTH);

	logic [WIDTH-1:0] avail;

	always_comb begin
		for (int i = 0; i < WIDTH; i++) begin
			avail[i] = !data[i] && (CW'(i) < room);
		end
	end

	always_comb begin
		bit_idx = '0;
		for (int i = WIDTH - 1; i >= 0; i--) begin
			if (avail[i]) begin
				bit_idx = BW'(i);
			end
		end
	end

	assign found = |avail;

endmodule

@@ rtl/core/frame_bitmap_allocator.sv @@
`timescale 1ns / 1ps

// First-fit page-frame allocator. One used/free bit per frame lives in a bitmap memory of
// WORD_BITS-bit words with a registered read port. After reset a clearing pass writes every
// word to zero, one per cycle, while no item is taken. Allocate scans the memory one word
// per cycle from word 0 and stops at the first word with a free bit below the frame count,
// or reports that no frame is left once the scan reaches that count. Free and test pass
// the index through the index split and then read its memory word; a free of a nonzero
// frame in range writes the word back with the bit cleared. An allocate of an entry that
// already holds a frame and the unused operation code go straight to the result. One item
// is in work at a time; a new item is taken while the last result still waits at the output
// register. frame_count sets how many frames are handed out, capped at MAX_FRAMES.
module frame_bitmap_allocator #(
	parameter int MAX_FRAMES = 4096,
	parameter int WORD_BITS  = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  fba_pkg::fba_req_t              req_item,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output fba_pkg::fba_rsp_t              rsp_item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fba_pkg::FCOUNT_W-1:0]   cfg_data
);

	localparam int NUM_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int SPAN_W    = $clog2(NUM_WORDS * WORD_BITS + 1);
	localparam int CW        = (SPAN_W > fba_pkg::FCOUNT_W) ? SPAN_W : fba_pkg::FCOUNT_W;
	localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);
	localparam logic [CW-1:0]      MAX_CW    = CW'(MAX_FRAMES);
	localparam logic [WORD_BITS-1:0] ONE_W   = {{(WORD_BITS-1){1'b0}}, 1'b1};

	fba_pkg::fba_state_t state_q, state_d;

	logic [fba_pkg::FCOUNT_W-1:0] frame_count_q;
	logic [WADDR_W-1:0]           chk_addr_q;
	logic [CW-1:0]                chk_base_q;
	logic [CW-1:0]                limit_q;
	logic [CW-1:0]                limit_d;
	logic [CW-1:0]                room;
	logic [CW-1:0]                found_frame;
	logic [fba_pkg::FRAME_W-1:0]  idx_q;
	fba_pkg::fba_req_t            item_q;
	fba_pkg::fba_rsp_t            res_q;
	fba_pkg::fba_rsp_t            res_init;
	logic                         rsp_valid_q;
	fba_pkg::fba_rsp_t            rsp_item_q;

	logic                         mem_we;
	logic [WADDR_W-1:0]           mem_waddr;
	logic [WORD_BITS-1:0]         mem_wdata;
	logic [WADDR_W-1:0]           mem_raddr;
	logic [WORD_BITS-1:0]         mem_rdata;

	logic [fba_pkg::FRAME_W-1:0]  word_s2;
	logic [BW-1:0]                bit_s2;
	logic [WADDR_W-1:0]           split_addr;
	logic                         in_range;
	logic                         scan_end;
	logic                         hit;
	logic [BW-1:0]                hit_bit;
	logic                         accept;
	logic                         load_rsp;

	fba_bitmap_ram #(
		.DEPTH  (NUM_WORDS),
		.WIDTH  (WORD_BITS),
		.ADDR_W (WADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	fba_index_split #(
		.WORD_BITS (WORD_BITS)
	) u_split (
		.clk     (clk),
		.idx     (idx_q),
		.word_s2 (word_s2),
		.bit_s2  (bit_s2)
	);

	fba_lowest_free #(
		.WIDTH (WORD_BITS),
		.CW    (CW)
	) u_find (
		.data    (mem_rdata),
		.room    (room),
		.found   (hit),
		.bit_idx (hit_bit)
	);

	assign cfg_ready   = 1'b1;
	assign rsp_valid   = rsp_valid_q;
	assign rsp_item    = rsp_item_q;
	assign accept      = req_valid && !req_stall;
	assign split_addr  = WADDR_W'(word_s2);
	assign in_range    = CW'(idx_q) < MAX_CW;
	assign scan_end    = chk_base_q >= limit_q;
	assign room        = limit_q - chk_base_q;
	assign found_frame = chk_base_q + CW'(hit_bit);
	assign limit_d     = (CW'(frame_count_q) < MAX_CW) ? CW'(frame_count_q) : MAX_CW;

	// Result before any bitmap work; later states overwrite what they learn.
	always_comb begin
		res_init = '0;
		res_init.status      = fba_pkg::STATUS_KEEP;
		res_init.entry_frame = req_item.current_frame;
		if (req_item.func == fba_pkg::FUNC_FREE) begin
			res_init.entry_frame = '0;
			if (req_item.current_frame != '0) begin
				res_init.status = fba_pkg::STATUS_DONE;
			end
		end else if (req_item.func == fba_pkg::FUNC_TEST) begin
			res_init.status = fba_pkg::STATUS_DONE;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = chk_addr_q;
		mem_wdata = '0;
		mem_raddr = chk_addr_q + WADDR_W'(1);
		load_rsp  = 1'b0;
		unique case (state_q)
			fba_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				if (chk_addr_q == LAST_WORD) begin
					state_d = fba_pkg::ST_IDLE;
				end
			end
			fba_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					priority if (req_item.func == fba_pkg::FUNC_ALLOC &&
							req_item.current_frame == '0) begin
						state_d = fba_pkg::ST_SCAN0;
					end else if (req_item.func == fba_pkg::FUNC_FREE ||
							req_item.func == fba_pkg::FUNC_TEST) begin
						state_d = fba_pkg::ST_SPLIT;
					end else begin
						state_d = fba_pkg::ST_DONE;
					end
				end
			end
			fba_pkg::ST_SCAN0: begin
				mem_raddr = '0;
				state_d   = fba_pkg::ST_SCAN;
			end
			fba_pkg::ST_SCAN: begin
				// read ahead one word; the word under check is chk_addr_q
				if (scan_end) begin
					state_d = fba_pkg::ST_DONE;
				end else if (hit) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rdata | (ONE_W << hit_bit);
					state_d   = fba_pkg::ST_DONE;
				end
			end
			fba_pkg::ST_SPLIT: begin
				state_d = fba_pkg::ST_SPLIT2;
			end
			fba_pkg::ST_SPLIT2: begin
				state_d = fba_pkg::ST_READ;
			end
			fba_pkg::ST_READ: begin
				mem_raddr = split_addr;
				state_d   = fba_pkg::ST_MODIFY;
			end
			fba_pkg::ST_MODIFY: begin
				mem_waddr = split_addr;
				mem_wdata = mem_rdata & ~(ONE_W << bit_s2);
				mem_we    = item_q.func == fba_pkg::FUNC_FREE && in_range && idx_q != '0;
				state_d   = fba_pkg::ST_DONE;
			end
			fba_pkg::ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					state_d  = fba_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fba_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= fba_pkg::ST_CLEAR;
			chk_addr_q    <= '0;
			rsp_valid_q   <= 1'b0;
			frame_count_q <= fba_pkg::FCOUNT_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				frame_count_q <= cfg_data;
			end
			if (state_q == fba_pkg::ST_CLEAR) begin
				chk_addr_q <= chk_addr_q + WADDR_W'(1);
			end else if (state_q == fba_pkg::ST_SCAN0) begin
				chk_addr_q <= '0;
			end else if (state_q == fba_pkg::ST_SCAN && !scan_end && !hit) begin
				chk_addr_q <= chk_addr_q + WADDR_W'(1);
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q  <= req_item;
			res_q   <= res_init;
			limit_q <= limit_d;
			idx_q   <= (req_item.func == fba_pkg::FUNC_TEST) ? req_item.frame_number
				: req_item.current_frame;
		end
		if (state_q == fba_pkg::ST_SCAN0) begin
			chk_base_q <= '0;
		end else if (state_q == fba_pkg::ST_SCAN) begin
			if (scan_end) begin
				res_q.status      <= fba_pkg::STATUS_NOFRAME;
				res_q.entry_frame <= '0;
			end else if (hit) begin
				res_q.status        <= fba_pkg::STATUS_DONE;
				res_q.entry_frame   <= found_frame[fba_pkg::FRAME_W-1:0];
				res_q.entry_present <= 1'b1;
				res_q.entry_rw      <= item_q.writable;
				res_q.entry_user    <= !item_q.for_kernel;
			end else begin
				chk_base_q <= chk_base_q + CW'(WORD_BITS);
			end
		end
		if (state_q == fba_pkg::ST_MODIFY && item_q.func == fba_pkg::FUNC_TEST) begin
			res_q.frame_in_use <= in_range && mem_rdata[bit_s2];
		end
		if (load_rsp) begin
			rsp_item_q <= res_q;
		end
	end

	a_noframe_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_item_q.status == fba_pkg::STATUS_NOFRAME
		|-> rsp_item_q.entry_frame == '0 && !rsp_item_q.entry_present)
		else $error("out-of-frames result carries entry fields");

	a_scan_write_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fba_pkg::ST_SCAN && mem_we |=> state_q == fba_pkg::ST_DONE)
		else $error("scan kept going after marking a frame");

	a_test_only_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_item_q.frame_in_use
		|-> rsp_item_q.status == fba_pkg::STATUS_DONE && !rsp_item_q.entry_present)
		else $error("frame_in_use set on a non-test result");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	localparam int NUM_FRAMES    = 4096;
	localparam int IDLE_LIMIT    = 4000;
	localparam int DRAIN_CYCLES  = 150;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 70;
	localparam int REQ_W         = $bits(fba_pkg::fba_req_t);
	localparam logic [fba_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         req_valid = 1'b0;
	logic                         req_stall;
	fba_pkg::fba_req_t            req_item  = '0;
	logic                         rsp_valid;
	logic                         rsp_stall = 1'b0;
	fba_pkg::fba_rsp_t            rsp_item;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [fba_pkg::FCOUNT_W-1:0] cfg_data  = '0;

	frame_bitmap_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// shadow of the used/free bitmap and the frame count register
	bit          frame_taken [NUM_FRAMES];
	int unsigned frame_limit = 32'(fba_pkg::FCOUNT_RESET);

	fba_pkg::fba_req_t pending_reqs [$];
	fba_pkg::fba_rsp_t expected_entries [$];
	fba_pkg::fba_rsp_t expected_rsp;
	int unsigned phase_counts [PHASES];
	int          send_idle_pct = 18;
	int          recv_idle_pct = 80;
	int          error_count   = 0;
	int          idle_cycles   = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic fba_pkg::fba_rsp_t predict_entry(fba_pkg::fba_req_t rq);
		fba_pkg::fba_rsp_t rsp;
		int unsigned       lim;
		int unsigned       f;
		rsp = '0;
		rsp.status = fba_pkg::STATUS_KEEP;
		rsp.entry_frame = rq.current_frame;
		lim = (frame_limit < NUM_FRAMES) ? frame_limit : NUM_FRAMES;
		case (rq.func)
			fba_pkg::FUNC_ALLOC: begin
				if (rq.current_frame == '0) begin
					// first fit: lowest clear bit below the usable count
					f = 0;
					while (f < lim && frame_taken[f])
						f++;
					if (f < lim) begin
						frame_taken[f] = 1'b1;
						rsp.status = fba_pkg::STATUS_DONE;
						rsp.entry_frame = f[fba_pkg::FRAME_W-1:0];
						rsp.entry_present = 1'b1;
						rsp.entry_rw = rq.writable;
						rsp.entry_user = ~rq.for_kernel;
					end else begin
						rsp.status = fba_pkg::STATUS_NOFRAME;
						rsp.entry_frame = '0;
					end
				end
			end
			fba_pkg::FUNC_FREE: begin
				if (rq.current_frame != '0) begin
					frame_taken[rq.current_frame] = 1'b0;
					rsp.status = fba_pkg::STATUS_DONE;
				end
				rsp.entry_frame = '0;
			end
			fba_pkg::FUNC_TEST: begin
				rsp.status = fba_pkg::STATUS_DONE;
				rsp.frame_in_use = frame_taken[rq.frame_number];
			end
			default: ;
		endcase
		return rsp;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic send_req(input logic [fba_pkg::FUNC_W-1:0] fn,
			input logic [fba_pkg::FRAME_W-1:0] cur,
			input logic [fba_pkg::FRAME_W-1:0] tst, input logic kern, input logic wr);
		fba_pkg::fba_req_t rq;
		rq.func = fn;
		rq.current_frame = cur;
		rq.frame_number = tst;
		rq.for_kernel = kern;
		rq.writable = wr;
		pending_reqs.push_back(rq);
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || expected_entries.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_frame_count(input logic [fba_pkg::FCOUNT_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		frame_limit = 32'(value);
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				expected_entries.push_back(predict_entry(req_item));
				void'(pending_reqs.pop_front());
			end
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req_item <= pending_reqs[0];
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_entries.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending: %p", rsp_item));
				end else begin
					expected_rsp = expected_entries.pop_front();
					if (rsp_item.status !== expected_rsp.status)
						report_mismatch($sformatf("status %0d, want %0d",
							rsp_item.status, expected_rsp.status));
					if (rsp_item.entry_frame !== expected_rsp.entry_frame)
						report_mismatch($sformatf("entry_frame %0d, want %0d",
							rsp_item.entry_frame, expected_rsp.entry_frame));
					if (rsp_item.entry_present !== expected_rsp.entry_present)
						report_mismatch($sformatf("entry_present %0b, want %0b",
							rsp_item.entry_present, expected_rsp.entry_present));
					if (rsp_item.entry_rw !== expected_rsp.entry_rw)
						report_mismatch($sformatf("entry_rw %0b, want %0b",
							rsp_item.entry_rw, expected_rsp.entry_rw));
					if (rsp_item.entry_user !== expected_rsp.entry_user)
						report_mismatch($sformatf("entry_user %0b, want %0b",
							rsp_item.entry_user, expected_rsp.entry_user));
					if (rsp_item.frame_in_use !== expected_rsp.frame_in_use)
						report_mismatch($sformatf("frame_in_use %0b, want %0b",
							rsp_item.frame_in_use, expected_rsp.frame_in_use));
				end
			end
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// watchdog: any handshake counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
					(cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		fba_pkg::fba_req_t rq;
		int unsigned       lim;
		int unsigned       span;
		int unsigned       pick;
		int unsigned       chunk;
		int                n;
		int                p;
		int                mode;
		phase_counts = '{40, 4096, 33, 100, 8191, 64, 0, 36};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset frame count, idle flags and extremes of each field
		send_req(fba_pkg::FUNC_ALLOC, 12'd0, 12'd0, 1'b0, 1'b1);
		send_req(fba_pkg::FUNC_ALLOC, 12'd0, 12'hFFF, 1'b1, 1'b0);
		send_req(fba_pkg::FUNC_ALLOC, 12'd0, 12'd0, 1'b0, 1'b0);
		send_req(fba_pkg::FUNC_ALLOC, 12'hFFF, 12'hFFF, 1'b1, 1'b1);
		send_req(fba_pkg::FUNC_TEST, 12'd0, 12'd1, 1'b0, 1'b0);
		send_req(fba_pkg::FUNC_TEST, 12'hFFF, 12'hFFF, 1'b1, 1'b1);
		send_req(fba_pkg::FUNC_TEST, 12'd0, 12'd0, 1'b0, 1'b0);
		send_req(fba_pkg::FUNC_FREE, 12'd1, 12'd0, 1'b0, 1'b0);
		send_req(fba_pkg::FUNC_FREE, 12'd0, 12'hFFF, 1'b1, 1'b1);
		send_req(fba_pkg::FUNC_FREE, 12'hFFF, 12'd0, 1'b0, 1'b0);
		send_req(fba_pkg::FUNC_TEST, 12'd0, 12'd1, 1'b0, 1'b0);
		send_req(FUNC_UNUSED, 12'hFFF, 12'hFFF, 1'b1, 1'b1);
		send_req(FUNC_UNUSED, 12'd0, 12'd0, 1'b0, 1'b0);
		wait_idle();
		// zero frames: nothing to hand out
		write_frame_count(13'd0);
		send_req(fba_pkg::FUNC_ALLOC, 12'd0, 12'd0, 1'b0, 1'b1);
		wait_idle();
		// only frame zero, which stays taken for good
		write_frame_count(13'd1);
		send_req(fba_pkg::FUNC_ALLOC, 12'd0, 12'd0, 1'b1, 1'b1);
		wait_idle();
		write_frame_count(13'd2);
		send_req(fba_pkg::FUNC_ALLOC, 12'd0, 12'd0, 1'b0, 1'b1);
		send_req(fba_pkg::FUNC_ALLOC, 12'd0, 12'd0, 1'b0, 1'b1);
		send_req(fba_pkg::FUNC_FREE, 12'd1, 12'd0, 1'b0, 1'b0);
		send_req(fba_pkg::FUNC_ALLOC, 12'd0, 12'd0, 1'b1, 1'b0);
		wait_idle();
		// above the frame array: saturate
		write_frame_count(13'h1FFF);
		send_req(fba_pkg::FUNC_ALLOC, 12'd0, 12'd0, 1'b0, 1'b1);
		wait_idle();
		write_frame_count(13'd4096);
		send_req(fba_pkg::FUNC_ALLOC, 12'd0, 12'd0, 1'b1, 1'b1);

		for (p = 0; p < PHASES; p++) begin
			wait_idle();
			if (p == 6)
				phase_counts[p] = $urandom_range(300, 1);
			write_frame_count(phase_counts[p][fba_pkg::FCOUNT_W-1:0]);
			mode = p * 3 / PHASES;
			case (mode)
				0: begin
					send_idle_pct = 18;
					recv_idle_pct = 80;
				end
				1: begin
					send_idle_pct = 80;
					recv_idle_pct = 18;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			lim = (frame_limit < NUM_FRAMES) ? frame_limit : NUM_FRAMES;
			// keep frees and tests near the frames that get handed out
			span = (lim < 200) ? lim + 2 : 200;
			n = 0;
			while (n < PHASE_ITEMS) begin
				chunk = $urandom_range(30, 5);
				repeat (chunk) begin
					rq = REQ_W'($urandom);
					pick = $urandom_range(99);
					if (pick < 45) begin
						rq.func = fba_pkg::FUNC_ALLOC;
						rq.current_frame = '0;
					end else if (pick < 53) begin
						rq.func = fba_pkg::FUNC_ALLOC;
					end else if (pick < 75) begin
						rq.func = fba_pkg::FUNC_FREE;
						rq.current_frame = fba_pkg::FRAME_W'($urandom_range(span));
					end else if (pick < 92) begin
						rq.func = fba_pkg::FUNC_TEST;
						rq.frame_number = fba_pkg::FRAME_W'($urandom_range(span));
					end else if (pick < 96) begin
						rq.func = FUNC_UNUSED;
					end
					pending_reqs.push_back(rq);
				end
				n += chunk;
				// now and then, hold the sender until everything has come back
				if ($urandom_range(2) == 0)
					wait_idle();
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_entries.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_entries.size()));
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/fba_pkg.sv
rtl/core/fba_bitmap_ram.sv
rtl/core/fba_index_split.sv
rtl/core/fba_lowest_free.sv
rtl/core/frame_bitmap_allocator.sv
tb/testbench.sv
